// ===== sv/sha256_pkg.sv =====
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

    localparam logic [1:0] OP_ABSORB      = 2'd0;
    localparam logic [1:0] OP_ABSORB_LAST = 2'd1;
    localparam logic [1:0] OP_FINISH      = 2'd2;

    localparam logic [7:0] PAD_MARKER = 8'h80;

    // Datapath command from the controller.
    typedef struct packed {
        logic       write_byte;   // write wr_byte at wr_addr
        logic [5:0] wr_addr;
        logic [7:0] wr_byte;
        logic       add_bits;     // count eight more message bits
        logic       put_length;   // write length into bytes 56..63
        logic       start_block;  // load working vars and begin rounds
        logic       round_step;   // run one round
        logic       fold_chain;   // add working vars into chain
        logic       reset_chain;  // restore initial hash and clear length
    } sha_cmd_t;

    typedef struct packed {
        logic last_round;
    } sha_stat_t;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [64];
        k = '{
            32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
            32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
            32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
            32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
            32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
            32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
            32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
            32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
            32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
            32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
            32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
        };
        return k[i];
    endfunction

    function automatic logic [31:0] initial_h(input logic [2:0] i);
        logic [31:0] h [8];
        h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
              32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return h[i];
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== sv/sha256_dp.sv =====
// Datapath: block words that double as the schedule window, round unit and chaining state.
module sha256_dp import sha256_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  sha_cmd_t    cmd,
    output sha_stat_t   stat,
    input  logic [2:0]  rd_index,
    output logic [31:0] rd_word
);

    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [31:0] h_reg [8];
    logic [63:0] bits_reg;
    logic [5:0]  round_reg;

    logic [31:0] w_cur, w_new, s0, s1;
    logic [31:0] big0, big1, ch, maj, t1, t2;
    logic [4:0]  lane_lsb;

    // Byte 0 of a word is its most significant byte.
    assign lane_lsb = {~cmd.wr_addr[1:0], 3'b000};

    assign w_cur = w_reg[0];
    assign s0 = ror32(w_reg[1], 7) ^ ror32(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = ror32(w_reg[14], 17) ^ ror32(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = s1 + w_reg[9] + s0 + w_reg[0];

    assign big1 = ror32(v_reg[4], 6) ^ ror32(v_reg[4], 11) ^ ror32(v_reg[4], 25);
    assign ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1   = v_reg[7] + big1 + ch + round_k(round_reg) + w_cur;
    assign big0 = ror32(v_reg[0], 2) ^ ror32(v_reg[0], 13) ^ ror32(v_reg[0], 22);
    assign maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2   = big0 + maj;

    assign stat.last_round = (round_reg == 6'd63);
    assign rd_word = h_reg[rd_index];

    always_ff @(posedge aclk) begin
        if (cmd.write_byte) begin
            w_reg[cmd.wr_addr[5:2]][lane_lsb +: 8] <= cmd.wr_byte;
        end
        if (cmd.put_length) begin
            w_reg[14] <= bits_reg[63:32];
            w_reg[15] <= bits_reg[31:0];
        end
        if (cmd.start_block) begin
            for (int k = 0; k < 8; k++) begin
                v_reg[k] <= h_reg[k];
            end
        end else if (cmd.round_step) begin
            for (int k = 0; k < 15; k++) begin
                w_reg[k] <= w_reg[k + 1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            round_reg <= '0;
            bits_reg  <= '0;
            for (int k = 0; k < 8; k++) begin
                h_reg[k] <= initial_h(3'(k));
            end
        end else begin
            if (cmd.start_block) begin
                round_reg <= '0;
            end else if (cmd.round_step) begin
                round_reg <= round_reg + 6'd1;
            end
            if (cmd.reset_chain) begin
                bits_reg <= '0;
                for (int k = 0; k < 8; k++) begin
                    h_reg[k] <= initial_h(3'(k));
                end
            end else begin
                if (cmd.add_bits) begin
                    bits_reg <= bits_reg + 64'd8;
                end
                if (cmd.fold_chain) begin
                    for (int k = 0; k < 8; k++) begin
                        h_reg[k] <= h_reg[k] + v_reg[k];
                    end
                end
            end
        end
    end

endmodule

// ===== sv/sha256_ctrl.sv =====
// Controller: byte intake, padding sequence, round sequencing and digest output.
module sha256_ctrl import sha256_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  op,
    input  logic [7:0]  data_byte,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [2:0]  word_index,
    output logic        last_word,
    output sha_cmd_t    cmd,
    input  sha_stat_t   stat
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_LEN   = 7'b0000100,
        ST_START = 7'b0001000,
        ST_ROUND = 7'b0010000,
        ST_FOLD  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [6:0]  fill_reg, fill_next;
    logic        fin_reg, fin_next;     // message end pending
    logic        final_reg, final_next; // current block holds the length
    logic [2:0]  idx_reg, idx_next;
    logic        take;

    assign s_tready   = (state_reg == ST_IDLE);
    assign take       = s_tvalid && s_tready;
    assign m_tvalid   = (state_reg == ST_OUT);
    assign word_index = idx_reg;
    assign last_word  = (idx_reg == 3'd7);

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        fin_next   = fin_reg;
        final_next = final_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.wr_addr = fill_reg[5:0];
        cmd.wr_byte = data_byte;
        case (state_reg)
            ST_IDLE: begin
                if (take && (op == OP_ABSORB || op == OP_ABSORB_LAST)) begin
                    cmd.write_byte = 1'b1;
                    cmd.add_bits   = 1'b1;
                    fill_next      = fill_reg + 7'd1;
                    fin_next       = (op == OP_ABSORB_LAST);
                    if (fill_reg == 7'd63) begin
                        state_next = ST_START;
                    end else if (op == OP_ABSORB_LAST) begin
                        state_next = ST_PAD;
                    end
                end else if (take && op == OP_FINISH) begin
                    fin_next   = 1'b1;
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                // Marker byte then zeros up to the length field or block end.
                cmd.write_byte = 1'b1;
                cmd.wr_byte    = (fill_reg[6]) ? 8'h00 : PAD_MARKER;
                cmd.wr_addr    = fill_reg[5:0];
                if (fill_reg[6]) begin
                    fill_next = {1'b1, fill_reg[5:0] + 6'd1};
                end else begin
                    fill_next = {1'b1, fill_reg[5:0] + 6'd1};
                end
                if (!fill_reg[6] && fill_reg[5:0] == 6'd63) begin
                    state_next = ST_START;
                    fill_next  = 7'd0;
                end else if (fill_reg[6] && fill_reg[5:0] == 6'd63) begin
                    state_next = ST_START;
                    fill_next  = 7'd0;
                end else if (fill_reg[5:0] == 6'd55 && !(fill_reg[6] == 1'b0
                             && fill_reg[5:0] > 6'd55)) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                cmd.put_length = 1'b1;
                final_next     = 1'b1;
                state_next     = ST_START;
            end
            ST_START: begin
                cmd.start_block = 1'b1;
                state_next      = ST_ROUND;
            end
            ST_ROUND: begin
                cmd.round_step = 1'b1;
                if (stat.last_round) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                cmd.fold_chain = 1'b1;
                fill_next      = 7'd0;
                if (final_reg) begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end else if (fin_reg) begin
                    // A block closed by the final byte still needs the marker at byte 0;
                    // a block closed by padding continues with zeros from byte 0.
                    fill_next  = {~fill_reg[6], 6'd0};
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7) begin
                        cmd.reset_chain = 1'b1;
                        fin_next   = 1'b0;
                        final_next = 1'b0;
                        fill_next  = 7'd0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            fin_reg   <= 1'b0;
            final_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            fin_reg   <= fin_next;
            final_reg <= final_next;
            idx_reg   <= idx_next;
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("input ready while emitting");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(idx_reg))
        else $error("digest word dropped");
    a_fold_after_round: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FOLD |-> $past(state_reg) == ST_ROUND)
        else $error("fold without rounds");

endmodule

// ===== sv/sha256_stream_hasher_top.sv =====
// Top level of the SHA-256 stream hasher: controller plus datapath.
// Throughput: one byte per cycle while filling; a full block is then processed (load,
// 64 rounds, fold) by the single round unit, and input is not ready meanwhile.
// Finish: one padding write per cycle (at most 56 per block), a length write, and the
// load, rounds and fold for each padding block, then 8 digest transfers. Reset
// (aresetn low, synchronous) restores the initial hash, clears length and fill.
module sha256_stream_hasher_top import sha256_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [1:0] op, [9:2] data_byte, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
    output logic        m_tlast    // last_word
);

    sha_cmd_t   cmd;
    sha_stat_t  stat;
    logic [2:0]  idx;
    logic [31:0] word;

    sha256_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .op(s_tdata[1:0]), .data_byte(s_tdata[9:2]),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .word_index(idx), .last_word(m_tlast),
        .cmd(cmd), .stat(stat)
    );

    sha256_dp u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .cmd(cmd), .stat(stat),
        .rd_index(idx), .rd_word(word)
    );

    assign m_tdata = {5'd0, idx, word};

endmodule

// ===== tb/sha256_stream_hasher_checker.sv =====
// Digest predictor and result checker for the SHA-256 stream hasher.
`timescale 1ns / 100ps
module sha256_stream_hasher_checker import sha256_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending_words,
    output int          digest_count
);

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_word_t;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] START_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic [31:0] hash_state [8];
    logic [7:0]  msg_block [64];
    logic [5:0]  block_fill;
    logic [63:0] length_bits;
    digest_word_t digest_queue [$];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
        v = hash_state;
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] += v[i];
    endtask

    task automatic absorb_byte(input logic [7:0] b);
        msg_block[block_fill] = b;
        length_bits += 64'd8;
        block_fill++;
        if (block_fill == 6'd0)
            compress_block();
    endtask

    task automatic finish_digest();
        int i;
        i = block_fill;
        msg_block[i++] = PAD_MARKER;
        if (i > 56) begin
            while (i < 64) msg_block[i++] = 8'h00;
            compress_block();
            i = 0;
        end
        while (i < 56) msg_block[i++] = 8'h00;
        for (int k = 0; k < 8; k++)
            msg_block[56 + k] = length_bits[63 - 8*k -: 8];
        compress_block();
        for (int j = 0; j < 8; j++)
            digest_queue.push_back('{hash_state[j], 3'(j), j == 7});
        hash_state = START_HASH;
        block_fill = '0;
        length_bits = '0;
    endtask

    always @(posedge aclk) begin
        logic [1:0]  op;
        digest_word_t exp_word;
        int errs;
        errs = 0;
        if (!aresetn) begin
            hash_state = START_HASH;
            block_fill = '0;
            length_bits = '0;
            digest_queue.delete();
            fail_count <= 0;
            digest_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (digest_queue.size() == 0) begin
                    $error("unexpected digest transfer %h", m_tdata);
                    errs++;
                end else begin
                    exp_word = digest_queue.pop_front();
                    if (m_tdata[31:0] !== exp_word.word) begin
                        $error("digest_word: expected %h, got %h", exp_word.word, m_tdata[31:0]);
                        errs++;
                    end
                    if (m_tdata[34:32] !== exp_word.index) begin
                        $error("word_index: expected %0d, got %0d", exp_word.index,
                               m_tdata[34:32]);
                        errs++;
                    end
                    if (m_tlast !== exp_word.last) begin
                        $error("last_word: expected %0d, got %0d", exp_word.last, m_tlast);
                        errs++;
                    end
                    if (exp_word.last)
                        digest_count <= digest_count + 1;
                end
            end
            if (s_tvalid && s_tready) begin
                op = s_tdata[1:0];
                if (op == OP_ABSORB || op == OP_ABSORB_LAST)
                    absorb_byte(s_tdata[9:2]);
                if (op == OP_ABSORB_LAST || op == OP_FINISH)
                    finish_digest();
            end
            fail_count <= fail_count + errs;
        end
        pending_words <= digest_queue.size();
    end

endmodule

// ===== tb/sha256_stream_hasher_top_test.sv =====
// Stimulus, clock, reset and verdict for the SHA-256 stream hasher test.
`timescale 1ns / 100ps
module sha256_stream_hasher_top_test;
    import sha256_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        m_tlast;
    int          fail_count;
    int          pending_words;
    int          digest_count;
    int          cycle_count = 0;
    int          sent_items;
    int          burst_left;

    sha256_stream_hasher_top DUT (.*);

    sha256_stream_hasher_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Receiver stalls at random, with steady readiness while bits 9:8 of the cycle count are both set.
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 3) != 0) || (cycle_count[9:8] == 2'b11);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Holds one transfer until accepted; bursts are separated by random gaps.
    task automatic send_item(input logic [1:0] op, input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, b, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (op != OP_UNUSED) sent_items++;
    endtask

    task automatic send_message(input int len, input logic [1:0] finish_op);
        for (int i = 0; i < len - (finish_op == OP_ABSORB_LAST); i++)
            send_item(OP_ABSORB, 8'($urandom));
        send_item(finish_op, 8'($urandom));
    endtask

    initial begin
        sent_items = 0;
        burst_left = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        // Directed: empty message, byte extremes, unused op, pad boundaries.
        send_item(OP_FINISH, 8'hff);
        send_item(OP_ABSORB_LAST, 8'h00);
        send_item(OP_ABSORB, 8'hff);
        send_item(OP_UNUSED, 8'haa);
        send_item(OP_ABSORB_LAST, 8'h55);
        send_item(OP_ABSORB, 8'haa);
        send_item(OP_FINISH, 8'h00);
        send_message(56, OP_FINISH);
        send_message(55, OP_ABSORB_LAST);
        send_message(64, OP_FINISH);
        send_message(64, OP_ABSORB_LAST);
        // Random messages, mostly short, a few crossing block boundaries.
        while (sent_items < 480) begin
            if ($urandom_range(0, 9) == 0)
                send_item(OP_UNUSED, 8'($urandom));
            else
                send_message(($urandom_range(0, 4) == 0) ? $urandom_range(50, 130)
                                                          : $urandom_range(0, 20),
                             $urandom_range(0, 1) ? OP_FINISH : OP_ABSORB_LAST);
        end
        s_tvalid <= 1'b0;
        while (pending_words != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        $display("Sent %0d items and checked %0d complete digests.", sent_items, digest_count);
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
